/* sv/clnw_pkg.sv */
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and the control store of the LCD nibble writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

  // Request modes.
  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_PUTC = 2'd1;
  localparam logic [1:0] MODE_GOTO = 2'd2;

  // Characters with a special meaning in put character mode.
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Commands built from a request.
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;

  localparam int PROG_DEPTH = 17;
  localparam int PC_W       = $clog2(PROG_DEPTH);

  // Entry points into the control store.
  localparam logic [PC_W-1:0] PC_INIT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_BYTE = PC_W'(15);

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_HI,
    SRC_LO
  } nib_src_e;

  typedef enum logic {
    OP_NEXT,
    OP_END
  } seq_op_e;

  // One control word: where the nibble comes from, whether register select
  // follows the request, the two waits and the sequencing operation.
  typedef struct packed {
    nib_src_e   src;
    logic       rs_from_req;
    logic [3:0] nib;
    logic [6:0] before_ms;
    logic [6:0] after_ms;
    seq_op_e    op;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{src: SRC_CONST, rs_from_req: 1'b0, nib: 4'h0, before_ms: 7'd0,
          after_ms: 7'd0, op: OP_END};
    case (pc)
      // Wake nibbles.
      PC_W'(0):  begin w.nib = 4'h3; w.before_ms = 7'd100; w.after_ms = 7'd50;
                       w.op = OP_NEXT; end
      PC_W'(1):  begin w.nib = 4'h3; w.after_ms = 7'd50;  w.op = OP_NEXT; end
      PC_W'(2):  begin w.nib = 4'h2; w.after_ms = 7'd100; w.op = OP_NEXT; end
      // Function set 0x28.
      PC_W'(3):  begin w.nib = 4'h2; w.op = OP_NEXT; end
      PC_W'(4):  begin w.nib = 4'h8; w.after_ms = 7'd2; w.op = OP_NEXT; end
      // Display off 0x08.
      PC_W'(5):  begin w.nib = 4'h0; w.op = OP_NEXT; end
      PC_W'(6):  begin w.nib = 4'h8; w.after_ms = 7'd2; w.op = OP_NEXT; end
      // Display on 0x0C.
      PC_W'(7):  begin w.nib = 4'h0; w.op = OP_NEXT; end
      PC_W'(8):  begin w.nib = 4'hC; w.after_ms = 7'd2; w.op = OP_NEXT; end
      // Clear 0x01.
      PC_W'(9):  begin w.nib = 4'h0; w.op = OP_NEXT; end
      PC_W'(10): begin w.nib = 4'h1; w.after_ms = 7'd2; w.op = OP_NEXT; end
      // Entry mode 0x04.
      PC_W'(11): begin w.nib = 4'h0; w.op = OP_NEXT; end
      PC_W'(12): begin w.nib = 4'h4; w.after_ms = 7'd2; w.op = OP_NEXT; end
      // Clear 0x01, end of the init sequence.
      PC_W'(13): begin w.nib = 4'h0; w.op = OP_NEXT; end
      PC_W'(14): begin w.nib = 4'h1; w.after_ms = 7'd2; w.op = OP_END; end
      // One byte from the request, high nibble first.
      PC_W'(15): begin w.src = SRC_HI; w.rs_from_req = 1'b1; w.op = OP_NEXT; end
      PC_W'(16): begin w.src = SRC_LO; w.rs_from_req = 1'b1; w.after_ms = 7'd2;
                       w.op = OP_END; end
      default:   w.op = OP_END;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/clnw_if.sv */
// ----------------------------------------------------------------------------
// clnw_in_if / clnw_out_if
// Valid/ready channels for requests and for nibble strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface clnw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [5:0] column;
  logic       line;

  modport source (output valid, mode, char_code, column, line, input ready);
  modport sink   (input valid, mode, char_code, column, line, output ready);
endinterface

interface clnw_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic [6:0] wait_before_ms;
  logic [6:0] wait_after_ms;
  logic       last;

  modport source (output valid, register_select, nibble, wait_before_ms,
                  wait_after_ms, last, input ready);
  modport sink   (input valid, register_select, nibble, wait_before_ms,
                  wait_after_ms, last, output ready);
endinterface

`default_nettype wire

/* sv/char_lcd_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Turns LCD requests into a burst of 4-bit nibble strobes with waits.
// ----------------------------------------------------------------------------
// A request is taken when the sequencer is free. The sequencer then issues
// one strobe per cycle from a small control store while the strobe sink
// keeps up. A put character or go to position request gives two strobes and
// an init request fifteen. The output register decouples the strobe sink,
// and the sequencer stalls while a strobe waits to be taken. A request with
// mode 3 is taken and produces no strobe.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clnw_in_if.sink     in_i,
  clnw_out_if.source  out_o
);

  logic                     busy_q, busy_d;
  logic [clnw_pkg::PC_W-1:0] pc_q, pc_d;
  logic [7:0]               byte_q, byte_d;
  logic                     rs_q, rs_d;
  logic                     out_valid_q;
  logic                     out_rs_q;
  logic [3:0]               out_nib_q;
  logic [6:0]               out_before_q;
  logic [6:0]               out_after_q;
  logic                     out_last_q;

  clnw_pkg::ucode_t         uw;
  logic                     in_acc;
  logic                     step;
  logic [3:0]               nib_sel;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;
  assign step       = busy_q && (!out_valid_q || out_o.ready);
  assign uw         = clnw_pkg::ucode_rom(pc_q);

  always_comb begin
    case (uw.src)
      clnw_pkg::SRC_HI: nib_sel = byte_q[7:4];
      clnw_pkg::SRC_LO: nib_sel = byte_q[3:0];
      default:          nib_sel = uw.nib;
    endcase
  end

  // Sequencing and request decode: the byte and its register select level.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    byte_d = byte_q;
    rs_d   = rs_q;
    if (step) begin
      if (uw.op == clnw_pkg::OP_END) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + clnw_pkg::PC_W'(1);
      end
    end
    if (in_acc) begin
      unique case (in_i.mode)
        clnw_pkg::MODE_INIT: begin
          busy_d = 1'b1;
          pc_d   = clnw_pkg::PC_INIT;
        end
        clnw_pkg::MODE_PUTC: begin
          busy_d = 1'b1;
          pc_d   = clnw_pkg::PC_BYTE;
          if (in_i.char_code == clnw_pkg::CHAR_FF) begin
            byte_d = clnw_pkg::CMD_CLEAR;
            rs_d   = 1'b0;
          end else if (in_i.char_code == clnw_pkg::CHAR_LF) begin
            byte_d = clnw_pkg::CMD_LINE_TWO;
            rs_d   = 1'b0;
          end else begin
            byte_d = in_i.char_code;
            rs_d   = 1'b1;
          end
        end
        clnw_pkg::MODE_GOTO: begin
          busy_d = 1'b1;
          pc_d   = clnw_pkg::PC_BYTE;
          // With a 6-bit column the address is simply line over column.
          byte_d = clnw_pkg::CMD_SET_DDRAM | {1'b0, in_i.line, in_i.column};
          rs_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
    if (step) begin
      out_rs_q     <= uw.rs_from_req ? rs_q : 1'b0;
      out_nib_q    <= nib_sel;
      out_before_q <= uw.before_ms;
      out_after_q  <= uw.after_ms;
      out_last_q   <= (uw.op == clnw_pkg::OP_END);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.register_select = out_rs_q;
  assign out_o.nibble          = out_nib_q;
  assign out_o.wait_before_ms  = out_before_q;
  assign out_o.wait_after_ms   = out_after_q;
  assign out_o.last            = out_last_q;

  // An accepted init request starts the sequencer at its entry point.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.mode == clnw_pkg::MODE_INIT) |=> busy_q && (pc_q == clnw_pkg::PC_INIT))
    else $error("init request did not start the sequence");

  // Issuing the final control word frees the sequencer.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (uw.op == clnw_pkg::OP_END) |=> !busy_q)
    else $error("sequencer still busy after its last strobe");

  // A busy sequencer with an empty output register always issues a strobe.
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !out_valid_q |=> out_valid_q)
    else $error("sequencer stalled with the output register empty");

  // The program counter never runs past the control store.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < clnw_pkg::PC_W'(clnw_pkg::PROG_DEPTH)))
    else $error("program counter beyond the control store");

endmodule

`default_nettype wire

/* sim/char_lcd_nibble_writer_test.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_test
// Self-checking bench for the LCD nibble writer. Requests are driven on the
// input channel, the strobes they should cause are worked out here and
// compared in order with what the block hands out, while both channels stall
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_nibble_writer_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Commands of the power-up sequence that the package does not name.
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;

  localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
  localparam logic [6:0] POWER_UP_MS     = 7'd100;
  localparam logic [6:0] WAKE_MS         = 7'd50;
  localparam logic [6:0] SETTLE_MS       = 7'd100;
  localparam logic [6:0] BYTE_MS         = 7'd2;
  localparam logic [6:0] LINE_TWO_BASE   = 7'h40;

  localparam int RANDOM_ITEMS = 90;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [5:0] column;
    logic       row;
  } lcd_request_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic [6:0] before_ms;
    logic [6:0] after_ms;
    logic       last;
  } strobe_t;

  class strobe_scoreboard;
    strobe_t pending_strobes[$];
    int      error_count;
    int      checked_count;

    function new();
      error_count   = 0;
      checked_count = 0;
    endfunction

    function int pending();
      return pending_strobes.size();
    endfunction

    function void push_strobe(logic rs, logic [3:0] nib, logic [6:0] before_ms,
                              logic [6:0] after_ms, logic last);
      pending_strobes.push_back(strobe_t'{rs, nib, before_ms, after_ms, last});
    endfunction

    // A byte always goes high nibble first, with the settle time after the low one.
    function void push_byte(logic rs, logic [7:0] value, logic last);
      push_strobe(rs, value[7:4], 7'd0, 7'd0, 1'b0);
      push_strobe(rs, value[3:0], 7'd0, BYTE_MS, last);
    endfunction

    function void add_request_strobes(lcd_request_t r);
      logic [6:0] addr;
      case (r.mode)
        clnw_pkg::MODE_INIT: begin
          push_strobe(1'b0, WAKE_NIBBLE, POWER_UP_MS, WAKE_MS, 1'b0);
          push_strobe(1'b0, WAKE_NIBBLE, 7'd0, WAKE_MS, 1'b0);
          push_strobe(1'b0, FOUR_BIT_NIBBLE, 7'd0, SETTLE_MS, 1'b0);
          push_byte(1'b0, CMD_FUNCTION_SET, 1'b0);
          push_byte(1'b0, CMD_DISPLAY_OFF, 1'b0);
          push_byte(1'b0, CMD_DISPLAY_ON, 1'b0);
          push_byte(1'b0, clnw_pkg::CMD_CLEAR, 1'b0);
          push_byte(1'b0, CMD_ENTRY_MODE, 1'b0);
          push_byte(1'b0, clnw_pkg::CMD_CLEAR, 1'b1);
        end
        clnw_pkg::MODE_PUTC: begin
          if (r.char_code == clnw_pkg::CHAR_FF) begin
            push_byte(1'b0, clnw_pkg::CMD_CLEAR, 1'b1);
          end else if (r.char_code == clnw_pkg::CHAR_LF) begin
            push_byte(1'b0, clnw_pkg::CMD_LINE_TWO, 1'b1);
          end else begin
            push_byte(1'b1, r.char_code, 1'b1);
          end
        end
        clnw_pkg::MODE_GOTO: begin
          addr = (r.row ? LINE_TWO_BASE : 7'd0) + {1'b0, r.column};
          push_byte(1'b0, clnw_pkg::CMD_SET_DDRAM | {1'b0, addr}, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function string describe(strobe_t s);
      return $sformatf("rs=%0d nibble=%h before=%0d after=%0d last=%0d",
                       s.rs, s.nib, s.before_ms, s.after_ms, s.last);
    endfunction

    function void report_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void check_strobe(strobe_t got);
      strobe_t want;
      if (pending_strobes.size() == 0) begin
        report_error($sformatf("strobe with nothing expected: %s", describe(got)));
        return;
      end
      want = pending_strobes.pop_front();
      checked_count++;
      if (got.rs !== want.rs || got.nib !== want.nib ||
          got.before_ms !== want.before_ms || got.after_ms !== want.after_ms ||
          got.last !== want.last) begin
        report_error($sformatf("expected %s, got %s", describe(want), describe(got)));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  bit   steady;
  bit   squeeze_pending;
  int   mode_tally[4];

  strobe_scoreboard board;

  clnw_in_if  req_if ();
  clnw_out_if strobe_if ();

  char_lcd_nibble_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (strobe_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  // Strobe sink: random stalls, one long hold-off to fill the block up, and
  // no stalls at all while the steady stretch runs.
  initial begin
    int  hold_left;
    bit  squeeze_done;
    hold_left    = 0;
    squeeze_done = 1'b0;
    strobe_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_pending && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        strobe_if.ready <= 1'b0;
      end else if (steady) begin
        strobe_if.ready <= 1'b1;
      end else begin
        strobe_if.ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_if.valid === 1'b1 && strobe_if.ready === 1'b1) begin
      board.check_strobe(strobe_t'{strobe_if.register_select, strobe_if.nibble,
                                   strobe_if.wait_before_ms, strobe_if.wait_after_ms,
                                   strobe_if.last});
    end
  end

  // Offers one request and returns at the edge where it is taken; valid is
  // left high so that back-to-back requests need no gap.
  task automatic send_request(input lcd_request_t r);
    while (!steady && $urandom_range(0, 99) < 24) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.mode      <= r.mode;
    req_if.char_code <= r.char_code;
    req_if.column    <= r.column;
    req_if.line      <= r.row;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    board.add_request_strobes(r);
    mode_tally[r.mode]++;
  endtask

  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int pick;
    pick        = $urandom_range(0, 99);
    r.char_code = 8'($urandom_range(0, 255));
    r.column    = 6'($urandom_range(0, 63));
    r.row       = 1'($urandom_range(0, 1));
    if (pick < 4) begin
      r.mode = clnw_pkg::MODE_INIT;
    end else if (pick < 9) begin
      r.mode = MODE_UNUSED;
    end else if (pick < 57) begin
      r.mode = clnw_pkg::MODE_PUTC;
      if ($urandom_range(0, 9) == 0) begin
        r.char_code = $urandom_range(0, 1) ? clnw_pkg::CHAR_FF : clnw_pkg::CHAR_LF;
      end
    end else begin
      r.mode = clnw_pkg::MODE_GOTO;
    end
    return r;
  endfunction

  initial begin
    lcd_request_t directed[$];
    int           counted;
    int           idx;
    lcd_request_t r;

    board           = new();
    steady          = 1'b0;
    squeeze_pending = 1'b0;
    foreach (mode_tally[m]) mode_tally[m] = 0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= clnw_pkg::MODE_PUTC;
    req_if.char_code <= 8'h00;
    req_if.column    <= 6'd0;
    req_if.line      <= 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Power-up sequence, form feed, newline, neighbours of form feed, byte extremes,
    // both line bases with the smallest and largest columns, and the unused mode.
    directed = '{
      '{clnw_pkg::MODE_INIT, 8'h00, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, clnw_pkg::CHAR_FF, 6'd0, 1'b0},
      '{clnw_pkg::MODE_PUTC, clnw_pkg::CHAR_LF, 6'd0, 1'b0},
      '{clnw_pkg::MODE_PUTC, 8'h0B, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, 8'h0D, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, 8'h00, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, 8'hFF, 6'd63, 1'b1},
      '{clnw_pkg::MODE_PUTC, 8'h41, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, 8'h55, 6'd0,  1'b0},
      '{clnw_pkg::MODE_PUTC, 8'hAA, 6'd0,  1'b0},
      '{clnw_pkg::MODE_GOTO, 8'h00, 6'd0,  1'b0},
      '{clnw_pkg::MODE_GOTO, 8'h00, 6'd39, 1'b0},
      '{clnw_pkg::MODE_GOTO, 8'h00, 6'd0,  1'b1},
      '{clnw_pkg::MODE_GOTO, 8'hFF, 6'd39, 1'b1},
      '{clnw_pkg::MODE_GOTO, 8'h00, 6'd63, 1'b0},
      '{clnw_pkg::MODE_GOTO, 8'h00, 6'd63, 1'b1},
      '{MODE_UNUSED,         8'hFF, 6'd63, 1'b1},
      '{clnw_pkg::MODE_PUTC, 8'h7E, 6'd0,  1'b0},
      '{clnw_pkg::MODE_INIT, 8'hFF, 6'd63, 1'b1}
    };
    foreach (directed[i]) send_request(directed[i]);

    counted = 0;
    idx     = 0;
    while (counted < RANDOM_ITEMS) begin
      r = random_request();
      if (idx == 10) squeeze_pending = 1'b1;
      steady = (counted >= 40 && counted < 70);
      send_request(r);
      if (r.mode != MODE_UNUSED) counted++;
      idx++;
    end
    steady = 1'b0;
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests taken: %0d init, %0d put character, %0d go to position, %0d unused",
             mode_tally[clnw_pkg::MODE_INIT], mode_tally[clnw_pkg::MODE_PUTC],
             mode_tally[clnw_pkg::MODE_GOTO], mode_tally[MODE_UNUSED]);
    $display("strobes checked: %0d, errors: %0d, cycles: %0d",
             board.checked_count, board.error_count, cycle_count);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/clnw_pkg.sv
sv/clnw_if.sv
sv/char_lcd_nibble_writer.sv
sim/char_lcd_nibble_writer_test.sv
